/* sv/isingml_pkg.sv */
// ----------------------------------------------------------------------------
// isingml_pkg
// shared constants, codes and types of the two-dimensional ising lattice block
// ----------------------------------------------------------------------------
package isingml_pkg;

	localparam int MAX_SIDE = 32;
	localparam int ROW_W    = $clog2(MAX_SIDE);
	localparam int IDX_W    = 5;
	localparam int SIDE_W   = 6;
	localparam int CNT_W    = 11;
	localparam int FRAC_W   = 16;
	localparam int DE_W     = 5;
	localparam int MAG_W    = 12;

	localparam int IN_BITS  = 2 + IDX_W + IDX_W + 1 + FRAC_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 1 + DE_W + MAG_W + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH_FOUR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH_EIGHT = 2'd2;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_TRIAL = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd10;
	localparam logic [SIDE_W-1:0] SIDE_MIN   = 6'd2;
	localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);

	localparam logic signed [DE_W-1:0] DE_FOUR = 5'sd4;

	typedef enum logic [4:0] {
		ST_CLEAR   = 5'b00001,
		ST_IDLE    = 5'b00010,
		ST_FETCH_C = 5'b00100,
		ST_FETCH_U = 5'b01000,
		ST_EVAL    = 5'b10000
	} state_t;

	// action in the lowest bits, random_fraction on top
	typedef struct packed {
		logic [FRAC_W-1:0] random_fraction;
		logic              spin_up;
		logic [IDX_W-1:0]  col;
		logic [IDX_W-1:0]  row;
		logic [1:0]        action;
	} in_item_t;

	typedef struct packed {
		logic                    index_error;
		logic [MAG_W-1:0]        magnetization;
		logic signed [DE_W-1:0]  energy_change;
		logic                    flipped;
	} out_item_t;

	function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] s);
		logic [SIDE_W-1:0] r;
		r = s;
		if (s < SIDE_MIN)
			r = SIDE_MIN;
		else if (s > SIDE_MAX)
			r = SIDE_MAX;
		return r;
	endfunction

endpackage

/* sv/ising_metropolis_lattice.sv */
// ----------------------------------------------------------------------------
// ising_metropolis_lattice
// periodic spin lattice with single-site metropolis trials, row-wide spin memory
// ----------------------------------------------------------------------------
// a trial reads the center, upper and lower rows one at a time through the single
//   read port of the row memory, while a write or read needs only the center row;
//   a new item is accepted only in idle, after the previous one has finished
// reset and every side_length write start a clearing pass over all 32 rows, one row
//   per cycle, during which no item is accepted; config writes are taken
// a finished result waits in the output register while the next item starts
// ----------------------------------------------------------------------------
module ising_metropolis_lattice (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// action, row, col, spin_up, random_fraction
	input  logic [isingml_pkg::IN_W-1:0]           s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// flipped, energy_change, magnetization, index_error
	output logic [isingml_pkg::OUT_W-1:0]          m_tdata,
	input  logic                                   cfg_we,
	input  logic [isingml_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [isingml_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import isingml_pkg::*;

	state_t                 state_q, state_d;
	logic [ROW_W-1:0]       clr_q;
	logic [SIDE_W-1:0]      side_q;
	logic [CNT_W-1:0]       sq_q;
	logic [FRAC_W-1:0]      th4_q, th8_q;
	logic [CNT_W-1:0]       cnt_q;
	in_item_t               item_q;
	logic [MAX_SIDE-1:0]    cen_q, up_q;
	logic                   m_valid_q;
	out_item_t              out_q;

	logic [MAX_SIDE-1:0]    mem [MAX_SIDE];
	logic [MAX_SIDE-1:0]    rd_q;
	logic [ROW_W-1:0]       rd_addr, wr_addr;
	logic [MAX_SIDE-1:0]    wr_data;
	logic                   mem_we;

	in_item_t               in_item;
	logic                   in_acc, side_wr;
	logic [SIDE_W-1:0]      side_new;
	logic                   bad, is_trial, fin_ok, finish, change;
	logic [IDX_W-1:0]       rl, rh, cl, ch;
	logic [MAX_SIDE-1:0]    base_row, new_row;
	logic                   s_bit, old_bit, new_bit;
	logic [2:0]             ups;
	logic [SIDE_W-1:0]      t6;
	logic signed [DE_W-1:0] de;
	logic                   acc;
	logic [CNT_W-1:0]       cnt_next;
	logic [MAG_W:0]         mag13;

	assign in_item  = in_item_t'(s_tdata[IN_BITS-1:0]);
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign side_wr  = cfg_we && (cfg_index == REG_SIDE_LENGTH);
	assign side_new = eff_side(cfg_data[SIDE_W-1:0]);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'(out_q);

	// addressing
	assign bad = ({1'b0, item_q.row} >= side_q) || ({1'b0, item_q.col} >= side_q);
	assign is_trial = (item_q.action == ACT_TRIAL) && !bad;
	assign rl = (item_q.row == '0) ? IDX_W'(side_q - 6'd1) : item_q.row - 5'd1;
	assign rh = (({1'b0, item_q.row} + 6'd1) == side_q) ? '0 : item_q.row + 5'd1;
	assign cl = (item_q.col == '0) ? IDX_W'(side_q - 6'd1) : item_q.col - 5'd1;
	assign ch = (({1'b0, item_q.col} + 6'd1) == side_q) ? '0 : item_q.col + 5'd1;

	// energy change from the four neighbours
	assign s_bit = cen_q[item_q.col[ROW_W-1:0]];
	assign ups = {2'b00, cen_q[cl[ROW_W-1:0]]} + {2'b00, cen_q[ch[ROW_W-1:0]]}
		+ {2'b00, up_q[item_q.col[ROW_W-1:0]]} + {2'b00, rd_q[item_q.col[ROW_W-1:0]]};
	assign t6 = {1'b0, ups, 2'b00} - 6'd8;
	assign de = s_bit ? $signed(t6[DE_W-1:0]) : -$signed(t6[DE_W-1:0]);
	always_comb begin
		if (de[DE_W-1] || (de == '0))
			acc = 1'b1;
		else if (de == DE_FOUR)
			acc = item_q.random_fraction < th4_q;
		else
			acc = item_q.random_fraction < th8_q;
	end

	// finishing and row update
	assign fin_ok = !m_valid_q || m_tready;
	always_comb begin
		finish   = 1'b0;
		change   = 1'b0;
		base_row = rd_q;
		new_bit  = item_q.spin_up;
		case (state_q)
			ST_FETCH_C: begin
				finish = fin_ok && !is_trial;
				change = (item_q.action == ACT_WRITE) && !bad;
			end
			ST_EVAL: begin
				finish   = fin_ok;
				change   = acc;
				base_row = cen_q;
				new_bit  = !s_bit;
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end
	assign old_bit = base_row[item_q.col[ROW_W-1:0]];
	always_comb begin
		new_row = base_row;
		new_row[item_q.col[ROW_W-1:0]] = new_bit;
	end
	assign cnt_next = change ? cnt_q + CNT_W'(new_bit && !old_bit) - CNT_W'(old_bit && !new_bit)
		: cnt_q;
	assign mag13 = {1'b0, cnt_next, 1'b0} - {2'b00, sq_q};

	// memory ports
	always_comb begin
		case (state_q)
			ST_IDLE:    rd_addr = in_item.row[ROW_W-1:0];
			ST_FETCH_C: rd_addr = is_trial ? rl[ROW_W-1:0] : item_q.row[ROW_W-1:0];
			ST_FETCH_U: rd_addr = rh[ROW_W-1:0];
			ST_EVAL:    rd_addr = rh[ROW_W-1:0];
			default:    rd_addr = '0;
		endcase
	end
	assign mem_we  = (state_q == ST_CLEAR) || (finish && change);
	assign wr_addr = (state_q == ST_CLEAR) ? clr_q : item_q.row[ROW_W-1:0];
	assign wr_data = (state_q == ST_CLEAR) ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:   if (clr_q == ROW_W'(MAX_SIDE - 1)) state_d = ST_IDLE;
			ST_IDLE:    if (in_acc) state_d = ST_FETCH_C;
			ST_FETCH_C: begin
				if (is_trial)
					state_d = ST_FETCH_U;
				else if (finish)
					state_d = ST_IDLE;
			end
			ST_FETCH_U: state_d = ST_EVAL;
			ST_EVAL:    if (finish) state_d = ST_IDLE;
			default:    state_d = ST_CLEAR;
		endcase
		if (side_wr)
			state_d = ST_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			side_q    <= SIDE_RESET;
			sq_q      <= CNT_W'({5'd0, SIDE_RESET} * {5'd0, SIDE_RESET});
			th4_q     <= '0;
			th8_q     <= '0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (side_wr)
				clr_q <= '0;
			else if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (finish)
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			if (side_wr) begin
				side_q <= side_new;
				sq_q   <= CNT_W'({6'd0, side_new} * {6'd0, side_new});
				cnt_q  <= '0;
			end else if (finish) begin
				cnt_q <= cnt_next;
			end
			if (cfg_we && (cfg_index == REG_THRESH_FOUR))
				th4_q <= cfg_data[FRAC_W-1:0];
			if (cfg_we && (cfg_index == REG_THRESH_EIGHT))
				th8_q <= cfg_data[FRAC_W-1:0];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_acc)
			item_q <= in_item;
		if (state_q == ST_FETCH_C)
			cen_q <= rd_q;
		if (state_q == ST_FETCH_U)
			up_q <= rd_q;
		if (finish) begin
			out_q.flipped       <= (state_q == ST_EVAL) && acc;
			out_q.energy_change <= (state_q == ST_EVAL) ? de : '0;
			out_q.magnetization <= mag13[MAG_W-1:0];
			out_q.index_error   <= bad;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= sq_q)
		else $error("up count exceeds active lattice size");

	a_side_clear: assert property (@(posedge clk) disable iff (!arst_n)
		side_wr |=> (state_q == ST_CLEAR) && (cnt_q == '0))
		else $error("side write did not start clearing pass");

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && out_q.index_error |-> !out_q.flipped && (out_q.energy_change == '0))
		else $error("index error with nonzero trial result");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != ST_IDLE))
		else $error("lattice written while idle");

endmodule

/* sim/tb_ising_metropolis_lattice.sv */
// ----------------------------------------------------------------------------
// tb_ising_metropolis_lattice
// self-checking bench: a directed table, then random phases over several
// lattice sides and acceptance thresholds; typed table rows are checked against
// their table values and every other result against an in-bench lattice predictor,
// with random idling on both stream sides in most phases
module tb_ising_metropolis_lattice;
	timeunit 1ns;
	timeprecision 1ps;

	import isingml_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 1000;

	// action in the lowest bits, random_fraction on top
	typedef struct packed {
		logic [FRAC_W-1:0] frac;
		logic              spin_up;
		logic [IDX_W-1:0]  col;
		logic [IDX_W-1:0]  row;
		logic [1:0]        action;
	} site_op_t;

	typedef struct packed {
		logic [1:0]              act;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic                    up;
		logic [FRAC_W-1:0]       frac;
		logic                    typed;
		logic                    flip;
		logic signed [DE_W-1:0]  de;
		logic signed [MAG_W-1:0] mag;
		logic                    err;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// lattice predictor state
	bit                spin_q [MAX_SIDE][MAX_SIDE];
	int                up_cnt;
	logic [SIDE_W-1:0] side_reg;
	logic [FRAC_W-1:0] thr_four;
	logic [FRAC_W-1:0] thr_eight;

	out_item_t exp_results [$];
	int        mism_cnt;
	int        idle_cycles;
	int        src_idle_pct;
	int        snk_idle_pct;
	bit        quiet;

	dir_row_t dir_tab [22] = '{
		'{ACT_READ,   5'd0,  5'd0,  1'b0, 16'h0000, 1'b1, 1'b0, 5'sd0,  -12'sd100, 1'b0},
		'{ACT_UNUSED, 5'd31, 5'd31, 1'b1, 16'hFFFF, 1'b1, 1'b0, 5'sd0,  -12'sd100, 1'b1},
		'{ACT_WRITE,  5'd0,  5'd0,  1'b1, 16'h0000, 1'b1, 1'b0, 5'sd0,  -12'sd98,  1'b0},
		'{ACT_WRITE,  5'd9,  5'd9,  1'b1, 16'h0000, 1'b1, 1'b0, 5'sd0,  -12'sd96,  1'b0},
		'{ACT_WRITE,  5'd10, 5'd0,  1'b1, 16'h0000, 1'b1, 1'b0, 5'sd0,  -12'sd96,  1'b1},
		'{ACT_WRITE,  5'd0,  5'd31, 1'b1, 16'h0000, 1'b1, 1'b0, 5'sd0,  -12'sd96,  1'b1},
		'{ACT_TRIAL,  5'd5,  5'd5,  1'b0, 16'h0000, 1'b1, 1'b0, 5'sd8,  -12'sd96,  1'b0},
		'{ACT_TRIAL,  5'd0,  5'd0,  1'b0, 16'hFFFF, 1'b1, 1'b1, -5'sd8, -12'sd98,  1'b0},
		'{ACT_TRIAL,  5'd0,  5'd9,  1'b0, 16'h0000, 1'b0, 1'b0, 5'sd0,  12'sd0,    1'b0},
		'{ACT_TRIAL,  5'd9,  5'd0,  1'b0, 16'h0000, 1'b0, 1'b0, 5'sd0,  12'sd0,    1'b0},
		'{ACT_WRITE,  5'd4,  5'd4,  1'b1, 16'h0000, 1'b0, 1'b0, 5'sd0,  12'sd0,    1'b0},
		'{ACT_WRITE,  5'd4,  5'd5,  1'b1, 16'h0000, 1'b0, 1'b0, 5'sd0,  12'sd0,    1'b0},
		'{ACT_WRITE,  5'd5,  5'd4,  1'b1, 16'h0000, 1'b0, 1'b0, 5'sd0,  12'sd0,    1'b0},
		'{ACT_WRITE,  5'd3,  5'd4,  1'b1, 16'h0000, 1'b0, 1'b0, 5'sd0,  12'sd0,    1'b0},
		'{ACT_TRIAL,  5'd4,  5'd4,  1'b0, 16'h0000, 1'b0, 1'b0, 5'sd0,  12'sd0,    1'b0},
		'{ACT_TRIAL,  5'd4,  5'd5,  1'b0, 16'hFFFF, 1'b0, 1'b0, 5'sd0,  12'sd0,    1'b0},
		'{ACT_TRIAL,  5'd31, 5'd0,  1'b0, 16'h0000, 1'b0, 1'b0, 5'sd0,  12'sd0,    1'b0},
		'{ACT_WRITE,  5'd9,  5'd9,  1'b0, 16'hFFFF, 1'b0, 1'b0, 5'sd0,  12'sd0,    1'b0},
		'{ACT_READ,   5'd9,  5'd9,  1'b1, 16'hFFFF, 1'b0, 1'b0, 5'sd0,  12'sd0,    1'b0},
		'{ACT_UNUSED, 5'd2,  5'd2,  1'b1, 16'h5A5A, 1'b0, 1'b0, 5'sd0,  12'sd0,    1'b0},
		'{ACT_TRIAL,  5'd9,  5'd9,  1'b1, 16'h0001, 1'b0, 1'b0, 5'sd0,  12'sd0,    1'b0},
		'{ACT_WRITE,  5'd31, 5'd31, 1'b0, 16'h0000, 1'b0, 1'b0, 5'sd0,  12'sd0,    1'b0}
	};

	ising_metropolis_lattice u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int lattice_len();
		int len;
		len = side_reg;
		if (len < 2)
			len = 2;
		else if (len > MAX_SIDE)
			len = MAX_SIDE;
		return len;
	endfunction

	function automatic void clear_lattice();
		foreach (spin_q[r, c])
			spin_q[r][c] = 1'b0;
		up_cnt = 0;
	endfunction

	function automatic int spin_of(int r, int c);
		return spin_q[r][c] ? 1 : -1;
	endfunction

	function automatic void set_site(int r, int c, bit up);
		if (spin_q[r][c] && !up)
			up_cnt--;
		else if (!spin_q[r][c] && up)
			up_cnt++;
		spin_q[r][c] = up;
	endfunction

	// applies one transaction to the predicted lattice, returns its result
	function automatic out_item_t lattice_step(site_op_t op);
		int len, r, c, rl, rh, cl, ch, s, nsum, de;
		bit bad, acc;
		out_item_t res;
		len = lattice_len();
		r = op.row;
		c = op.col;
		bad = (r >= len) || (c >= len);
		res = '0;
		if (!bad && op.action == ACT_WRITE) begin
			set_site(r, c, op.spin_up);
		end else if (!bad && op.action == ACT_TRIAL) begin
			rl = (r == 0) ? len - 1 : r - 1;
			rh = (r + 1 == len) ? 0 : r + 1;
			cl = (c == 0) ? len - 1 : c - 1;
			ch = (c + 1 == len) ? 0 : c + 1;
			s = spin_of(r, c);
			nsum = spin_of(r, cl) + spin_of(r, ch) + spin_of(rl, c) + spin_of(rh, c);
			de = 2 * s * nsum;
			if (de <= 0)
				acc = 1'b1;
			else if (de == 4)
				acc = op.frac < thr_four;
			else
				acc = op.frac < thr_eight;
			if (acc) begin
				set_site(r, c, s < 0);
				res.flipped = 1'b1;
			end
			res.energy_change = DE_W'(de);
		end
		res.magnetization = MAG_W'(2 * up_cnt - len * len);
		res.index_error = bad;
		return res;
	endfunction

	function automatic void note_mismatch(string msg);
		mism_cnt++;
		if (mism_cnt <= 10)
			$display("mismatch at %0t ns: %s", $realtime, msg);
	endfunction

	// queues one expected result behind the earlier ones
	function automatic void add_expected(out_item_t res);
		exp_results.insert(exp_results.size(), res);
	endfunction

	// random transaction; seeding draws only in-range spin writes
	function automatic site_op_t random_op(bit seeding);
		site_op_t op;
		int len, p, off;
		len = lattice_len();
		p = $urandom_range(0, 99);
		op.row = IDX_W'($urandom_range(0, len - 1));
		op.col = IDX_W'($urandom_range(0, len - 1));
		op.spin_up = 1'($urandom_range(0, 1));
		off = $urandom_range(0, 4) - 2;
		case ($urandom_range(0, 3))
			0: op.frac = FRAC_W'(int'(thr_four) + off);
			1: op.frac = FRAC_W'(int'(thr_eight) + off);
			default: op.frac = FRAC_W'($urandom_range(0, 65535));
		endcase
		if (seeding)
			op.action = ACT_WRITE;
		else if (p < 55)
			op.action = ACT_TRIAL;
		else if (p < 80)
			op.action = ACT_WRITE;
		else if (p < 92)
			op.action = ACT_READ;
		else
			op.action = ACT_UNUSED;
		if (!seeding && len < MAX_SIDE && $urandom_range(0, 99) < 8) begin
			if ($urandom_range(0, 1))
				op.row = IDX_W'($urandom_range(len, MAX_SIDE - 1));
			else
				op.col = IDX_W'($urandom_range(len, MAX_SIDE - 1));
		end
		return op;
	endfunction

	task automatic send_op(input site_op_t op, input bit typed, input out_item_t want);
		out_item_t model;
		if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = IN_W'(op);
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		model = lattice_step(op);
		add_expected(typed ? want : model);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			REG_SIDE_LENGTH: begin
				side_reg = val[SIDE_W-1:0];
				clear_lattice();
			end
			REG_THRESH_FOUR: thr_four = val;
			REG_THRESH_EIGHT: thr_eight = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] side, input logic [FRAC_W-1:0] t4,
			input logic [FRAC_W-1:0] t8, input int n_ops, input int src_pct, input int snk_pct);
		site_op_t op;
		while (exp_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		write_reg(REG_SIDE_LENGTH, side);
		write_reg(REG_THRESH_FOUR, t4);
		write_reg(REG_THRESH_EIGHT, t8);
		cfg_we = 1'b0;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		for (int i = 0; i < n_ops; i++) begin
			op = random_op(i < n_ops / 5);
			send_op(op, 1'b0, '0);
		end
		s_tvalid = 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		out_item_t got, want;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			got = out_item_t'(m_tdata[OUT_BITS-1:0]);
			if (exp_results.size() == 0) begin
				note_mismatch($sformatf("result with none expected, data %h", m_tdata));
			end else begin
				want = exp_results.pop_front();
				if (got.flipped !== want.flipped)
					note_mismatch($sformatf("flipped expected %0d, got %0d",
						want.flipped, got.flipped));
				if (got.energy_change !== want.energy_change)
					note_mismatch($sformatf("energy_change expected %0d, got %0d",
						want.energy_change, got.energy_change));
				if (got.magnetization !== want.magnetization)
					note_mismatch($sformatf("magnetization expected %0d, got %0d",
						$signed(want.magnetization), $signed(got.magnetization)));
				if (got.index_error !== want.index_error)
					note_mismatch($sformatf("index_error expected %0d, got %0d",
						want.index_error, got.index_error));
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("** ising_metropolis_lattice: FAILED **");
			$finish;
		end
	end

	// result side backpressure
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0 && !quiet) begin
				m_tready = 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 99) < snk_idle_pct) begin
				m_tready = 1'b0;
				stall_left = $urandom_range(1, 15) - 1;
			end else begin
				m_tready = 1'b1;
				stall_left = 0;
			end
		end
	end

	initial begin
		site_op_t op;
		out_item_t want;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SIDE_LENGTH;
		cfg_data = '0;
		mism_cnt = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		src_idle_pct = 20;
		snk_idle_pct = 20;
		side_reg = SIDE_RESET;
		thr_four = '0;
		thr_eight = '0;
		clear_lattice();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			op.action = dir_tab[i].act;
			op.row = dir_tab[i].row;
			op.col = dir_tab[i].col;
			op.spin_up = dir_tab[i].up;
			op.frac = dir_tab[i].frac;
			want.flipped = dir_tab[i].flip;
			want.energy_change = dir_tab[i].de;
			want.magnetization = dir_tab[i].mag;
			want.index_error = dir_tab[i].err;
			send_op(op, dir_tab[i].typed, want);
		end
		s_tvalid = 1'b0;

		run_phase(16'd2,  16'hFFFF, 16'hFFFF, 70, 25, 25);
		run_phase(16'd3,  16'h8000, 16'h2000, 70, 0, 0);
		run_phase(16'd0,  FRAC_W'($urandom), FRAC_W'($urandom), 50, 30, 10);
		run_phase(16'd32, FRAC_W'($urandom), FRAC_W'($urandom), 40, 15, 30);
		run_phase(16'd63, 16'h0000, 16'hFFFF, 30, 20, 20);
		run_phase(16'd5,  FRAC_W'($urandom), 16'h0000, 60, 10, 40);
		quiet = 1'b1;
		// upper data bits lie outside the side register
		run_phase(16'hFF04, FRAC_W'($urandom), FRAC_W'($urandom), 80, 0, 0);

		while (exp_results.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (mism_cnt == 0)
			$display("** ising_metropolis_lattice: PASSED **");
		else
			$display("** ising_metropolis_lattice: FAILED **");
		$finish;
	end

endmodule

/* filelist.f */
sv/isingml_pkg.sv
sv/ising_metropolis_lattice.sv
sim/tb_ising_metropolis_lattice.sv
